[hdl/led_matrix_on_time_accumulator_core_macros.svh]
// ----------------------------------------------------------------------------
// LED matrix on-time accumulator: assertion macros
// Concurrent checks, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_ON_TIME_ACCUMULATOR_CORE_MACROS_SVH
`define LED_MATRIX_ON_TIME_ACCUMULATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define LMOTA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define LMOTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LMOTA_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define LMOTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[hdl/lmota_pkg.sv]
// ----------------------------------------------------------------------------
// LED matrix on-time accumulator package
// Sizes, request codes, the queued operation type and saturation helpers.
// ----------------------------------------------------------------------------
package lmota_pkg;

  localparam int DECODERS   = 4;
  localparam int LAYERS     = 5;
  localparam int LINES      = 8;
  localparam int COUNT_BITS = 16;

  localparam int GRID_SIDE   = 5;
  localparam int PIN_DECODER = 3;
  localparam int SEL_W       = 3;
  localparam int LINE_W      = 3;
  localparam int OUT_W       = 16;
  localparam int LIN_W       = 6;
  localparam int DEC_W       = (DECODERS > 1) ? $clog2(DECODERS) : 1;
  localparam int LAYER_W     = (LAYERS > 1) ? $clog2(LAYERS) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] REQ_SEL      = 3'd0;
  localparam logic [2:0] REQ_DEC_EN   = 3'd1;
  localparam logic [2:0] REQ_LAYER_EN = 3'd2;
  localparam logic [2:0] REQ_PIN      = 3'd3;
  localparam logic [2:0] REQ_TICK     = 3'd4;
  localparam logic [2:0] REQ_CLEAR    = 3'd5;
  localparam logic [2:0] REQ_READ     = 3'd6;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // One classified item as handed from the front to the back.
  typedef struct packed {
    logic [1:0]                        bump_cnt;
    logic                              clear;
    logic                              read;
    logic [DECODERS-1:0]               dec_on;
    logic [DECODERS-1:0][SEL_W-1:0]    dec_line;
    logic [LAYERS-1:0]                 layer_on;
    logic                              rd_ok;
    logic [DEC_W-1:0]                  rd_dec;
    logic [LAYER_W-1:0]                rd_layer;
    logic [LINE_W-1:0]                 rd_line;
  } op_t;

  function automatic logic [COUNT_BITS-1:0] sat_add(
    input logic [COUNT_BITS-1:0] base,
    input logic [1:0]            inc
  );
    logic [COUNT_BITS:0] sum;
    sum = {1'b0, base} + (COUNT_BITS + 1)'(inc);
    if (sum > {1'b0, COUNT_MAX}) begin
      return COUNT_MAX;
    end
    return sum[COUNT_BITS-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+OUT_W-1:0] wide;
    wide = (COUNT_BITS + OUT_W)'(v);
    if ((wide >> OUT_W) != '0) begin
      return {OUT_W{1'b1}};
    end
    return wide[OUT_W-1:0];
  endfunction

endpackage

[hdl/lmota_front.sv]
// ----------------------------------------------------------------------------
// LED matrix on-time accumulator: front end
// Decodes requests, owns the decoder and layer settings, and emits one
// classified operation per item of a used request code, with a snapshot of the lit pattern.
// ----------------------------------------------------------------------------
module lmota_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [2:0]        req_type,
  input  logic [2:0]        unit_index,
  input  logic [7:0]        set_value,
  input  logic [2:0]        led_layer,
  input  logic [2:0]        led_row,
  input  logic [2:0]        led_col,
  output logic              push,
  output lmota_pkg::op_t    op
);
  import lmota_pkg::*;

  logic [DECODERS-1:0][SEL_W-1:0] sel, sel_next;
  logic [DECODERS-1:0]            dec_on, dec_on_next;
  logic [LAYERS-1:0]              lay_on, lay_on_next;
  logic [LIN_W-1:0]               lin_idx;
  logic [2:0]                     rd_dec_full;
  logic                           set_on;

  assign set_on      = |set_value;
  assign lin_idx     = LIN_W'(led_row) * LIN_W'(GRID_SIDE) + LIN_W'(led_col);
  assign rd_dec_full = lin_idx[5:3];

  always_comb begin
    sel_next    = sel;
    dec_on_next = dec_on;
    lay_on_next = lay_on;
    op          = '0;
    case (req_type)
      REQ_SEL: begin
        for (int d = 0; d < DECODERS; d++) begin
          if (unit_index == 3'(d)) sel_next[d] = set_value[SEL_W-1:0];
        end
        op.bump_cnt = 2'd1;
      end
      REQ_DEC_EN: begin
        for (int d = 0; d < DECODERS; d++) begin
          if (unit_index == 3'(d)) dec_on_next[d] = set_on;
        end
        op.bump_cnt = 2'd1;
      end
      REQ_LAYER_EN: begin
        for (int l = 0; l < LAYERS; l++) begin
          if (unit_index == 3'(l)) lay_on_next[l] = set_on;
        end
        op.bump_cnt = 2'd1;
      end
      REQ_PIN: begin
        for (int d = 0; d < DECODERS; d++) begin
          if (d == PIN_DECODER) dec_on_next[d] = set_on;
        end
        op.bump_cnt = 2'd2;
      end
      REQ_TICK: begin
        op.bump_cnt = 2'd1;
      end
      REQ_CLEAR: begin
        op.clear    = 1'b1;
        op.bump_cnt = 2'd1;
      end
      REQ_READ: begin
        op.read = 1'b1;
      end
      default: begin
      end
    endcase
    op.dec_on   = dec_on_next;
    op.dec_line = sel_next;
    op.layer_on = lay_on_next;
    op.rd_ok    = (int'(led_layer) < LAYERS) && (int'(led_row) < GRID_SIDE) &&
                  (int'(led_col) < GRID_SIDE) && (int'(rd_dec_full) < DECODERS);
    op.rd_dec   = rd_dec_full[DEC_W-1:0];
    op.rd_layer = led_layer[LAYER_W-1:0];
    op.rd_line  = lin_idx[LINE_W-1:0];
  end

  // Unused request code produces nothing downstream.
  assign push = accept && (op.bump_cnt != 2'd0 || op.read);

  always_ff @(posedge clk) begin
    if (rst) begin
      sel    <= '0;
      dec_on <= '0;
      lay_on <= '0;
    end else if (accept) begin
      sel    <= sel_next;
      dec_on <= dec_on_next;
      lay_on <= lay_on_next;
    end
  end

endmodule

[hdl/lmota_queue.sv]
// ----------------------------------------------------------------------------
// LED matrix on-time accumulator: operation queue
// Short FIFO that decouples the front end from the counter bank.
// ----------------------------------------------------------------------------
module lmota_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lmota_pkg::op_t    push_op,
  input  logic              pop,
  output lmota_pkg::op_t    head,
  output logic              empty,
  output logic              full
);
  import lmota_pkg::*;

  op_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

[hdl/lmota_back.sv]
// ----------------------------------------------------------------------------
// LED matrix on-time accumulator: counter bank
// Applies bumps and clears to every counter in parallel and serves reads
// through a registered output stage.
// ----------------------------------------------------------------------------
module lmota_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         op_valid,
  input  lmota_pkg::op_t               op,
  output logic                         op_ready,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lmota_pkg::OUT_W-1:0]  intensity
);
  import lmota_pkg::*;

  logic [COUNT_BITS-1:0] cnt [DECODERS][LAYERS][LINES];
  logic                  take;

  assign op_ready = !out_valid || out_ready;
  assign take     = op_valid && op_ready;

  // Each counter sees only its own hit term; clear zeroes before the bump.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < DECODERS; d++) begin
        for (int l = 0; l < LAYERS; l++) begin
          for (int n = 0; n < LINES; n++) cnt[d][l][n] <= '0;
        end
      end
    end else if (take && !op.read) begin
      for (int d = 0; d < DECODERS; d++) begin
        for (int l = 0; l < LAYERS; l++) begin
          for (int n = 0; n < LINES; n++) begin
            cnt[d][l][n] <= sat_add(op.clear ? '0 : cnt[d][l][n],
                                    (op.dec_on[d] && op.layer_on[l] &&
                                     op.dec_line[d] == LINE_W'(n)) ? op.bump_cnt : 2'd0);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && op.read) begin
      intensity <= op.rd_ok ? sat_out(cnt[op.rd_dec][op.rd_layer][op.rd_line]) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && op.read) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[hdl/led_matrix_on_time_accumulator_core.sv]
// A read item's result is queued at the accepting edge, then registered by
// the counter bank when it takes the item. Throughput: one item per cycle
// unless the queue is full or a result waits on out_ready; all 160 counters
// update in the same cycle, so the bank's single update port sets the rate.
// Reset (rst, synchronous): clears decoder selects, enable masks and every
// counter at once; no clearing sweep, items are taken the cycle after.
// ----------------------------------------------------------------------------
// LED matrix on-time accumulator core
// Tracks per-LED lit time of a multiplexed cube driven by 3-to-8 decoders and
// layer switches, and returns saturating on-counts on request.
// ----------------------------------------------------------------------------
`include "led_matrix_on_time_accumulator_core_macros.svh"

module led_matrix_on_time_accumulator_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   req_type,
  input  logic [2:0]                   unit_index,
  input  logic [7:0]                   set_value,
  input  logic [2:0]                   led_layer,
  input  logic [2:0]                   led_row,
  input  logic [2:0]                   led_col,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lmota_pkg::OUT_W-1:0]  intensity
);
  import lmota_pkg::*;

  logic accept;
  logic q_push, q_pop, q_empty, q_full, back_ready;
  op_t  front_op, q_head;

  // Take an item whenever the queue has room and reset is released; the
  // settings update right away in the front so later items see them in order.
  assign in_ready = !rst && !q_full;
  assign accept   = in_valid && in_ready;

  lmota_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .req_type   (req_type),
    .unit_index (unit_index),
    .set_value  (set_value),
    .led_layer  (led_layer),
    .led_row    (led_row),
    .led_col    (led_col),
    .push       (q_push),
    .op         (front_op)
  );

  // Hold classified items until the counter bank takes them.
  lmota_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (front_op),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  // Advance the queue head whenever the output stage can absorb a result.
  assign q_pop = !q_empty && back_ready;

  lmota_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (!q_empty),
    .op        (q_head),
    .op_ready  (back_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .intensity (intensity)
  );

  `LMOTA_ASSERT_NOW(a_no_overflow, clk, rst, q_push, !q_full, "queue push while full")
  `LMOTA_ASSERT_NOW(a_no_underflow, clk, rst, q_pop, !q_empty, "queue pop while empty")
  `LMOTA_ASSERT_NEXT(a_read_result, clk, rst, q_pop && q_head.read, out_valid, "read item lost")
  `LMOTA_ASSERT_NOW(a_no_drop, clk, rst, out_valid && !out_ready, !q_pop || !q_head.read, "result overwritten")

endmodule
